>>> hw/rtl/dcl_pkg.sv
// Package for the distance cull / LOD select unit: stage map, pipeline word type,
// constants and the per-stage step functions of the iterative units.
// No dependencies.
`default_nettype none
package dcl_pkg;

	localparam int NUM_STAGES = 86;

	localparam int ST_DIFF   = 1;
	localparam int ST_SQ     = 2;
	localparam int ST_D2     = 3;
	localparam int ST_PREP   = 4;
	localparam int ST_VMUL   = 5;
	localparam int ST_VOL    = 6;
	localparam int ST_DSQ0   = 4;
	localparam int ST_DSQN   = 28;
	localparam int ST_SCALE  = 29;
	localparam int ST_RUNG   = 30;
	localparam int ST_DIV0   = 5;
	localparam int ST_DIVN   = 36;
	localparam int ST_SSA    = 37;
	localparam int ST_LDIV0  = 38;
	localparam int ST_LDIVN  = 69;
	localparam int ST_LSQ0   = 70;
	localparam int ST_LSQN   = 85;
	localparam int ST_LOD    = 86;

	localparam logic [2:0] CFG_CAMERA_X   = 3'd0;
	localparam logic [2:0] CFG_CAMERA_Y   = 3'd1;
	localparam logic [2:0] CFG_CAMERA_Z   = 3'd2;
	localparam logic [2:0] CFG_FOV        = 3'd3;
	localparam logic [2:0] CFG_DISCARD    = 3'd4;
	localparam logic [2:0] CFG_LOD_START  = 3'd5;
	localparam logic [2:0] CFG_LOD_END    = 3'd6;

	localparam logic [15:0] FOV_RESET = 16'd17920;

	localparam logic [1:0] RSN_KEEP = 2'd0;
	localparam logic [1:0] RSN_SIZE = 2'd1;
	localparam logic [1:0] RSN_SSA  = 2'd2;

	localparam logic [18:0] VOL_K = 19'd274517;
	localparam logic [16:0] LOD_ONE = 17'd65536;

	localparam int RUNGS = 5;
	localparam logic [31:0] RUNG_VOL [RUNGS] = '{
		32'd15360, 32'd102400, 32'd512000, 32'd972800, 32'd3328000};
	// rung distance * 70 * 65536
	localparam logic [40:0] RUNG_DIST [RUNGS] = '{
		41'd206438400, 41'd458752000, 41'd734003200, 41'd917504000, 41'd1376256000};

	typedef enum logic [1:0] {LM_DIV, LM_FULL, LM_ZERO} lod_mode_t;

	typedef struct packed {
		logic [24:0] adx;
		logic [24:0] ady;
		logic [24:0] adz;
		logic [23:0] r;
		logic [49:0] sqx;
		logic [49:0] sqy;
		logic [49:0] sqz;
		logic [41:0] rr;
		logic        rbig;
		logic [41:0] plo;
		logic [41:0] phi;
		logic [62:0] r3;
		logic [50:0] mlo;
		logic [49:0] mhi;
		logic [31:0] vol;
		logic [49:0] d2;
		logic [49:0] sq_x;
		logic [25:0] sq_rem;
		logic [24:0] sq_root;
		logic [40:0] scaled;
		logic        rung;
		logic [50:0] dv_d;
		logic [50:0] dv_rem;
		logic [31:0] dv_q;
		logic        ssa_sat;
		logic [31:0] ssa;
		logic [1:0]  reason;
		lod_mode_t   mode;
		logic [31:0] rng;
		logic [31:0] ld_rem;
		logic [31:0] ld_q;
		logic [31:0] ls_x;
		logic [16:0] ls_rem;
		logic [15:0] ls_root;
		logic [16:0] lod;
	} pl_t;

	function automatic pl_t dist_step(pl_t p);
		logic [27:0] tmp;
		logic [27:0] trial;
		pl_t n;
		n = p;
		tmp = {p.sq_rem, p.sq_x[49:48]};
		trial = {1'b0, p.sq_root, 2'b01};
		n.sq_x = {p.sq_x[47:0], 2'b00};
		if (tmp >= trial) begin
			n.sq_rem = 26'(tmp - trial);
			n.sq_root = {p.sq_root[23:0], 1'b1};
		end else begin
			n.sq_rem = tmp[25:0];
			n.sq_root = {p.sq_root[23:0], 1'b0};
		end
		return n;
	endfunction

	function automatic pl_t ssa_div_step(pl_t p);
		logic [51:0] sh;
		pl_t n;
		n = p;
		sh = {p.dv_rem, 1'b0};
		if (sh >= {1'b0, p.dv_d}) begin
			n.dv_rem = 51'(sh - {1'b0, p.dv_d});
			n.dv_q = {p.dv_q[30:0], 1'b1};
		end else begin
			n.dv_rem = sh[50:0];
			n.dv_q = {p.dv_q[30:0], 1'b0};
		end
		return n;
	endfunction

	function automatic pl_t lod_div_step(pl_t p);
		logic [32:0] sh;
		pl_t n;
		n = p;
		sh = {p.ld_rem, 1'b0};
		if (sh >= {1'b0, p.rng}) begin
			n.ld_rem = 32'(sh - {1'b0, p.rng});
			n.ld_q = {p.ld_q[30:0], 1'b1};
		end else begin
			n.ld_rem = sh[31:0];
			n.ld_q = {p.ld_q[30:0], 1'b0};
		end
		return n;
	endfunction

	function automatic pl_t lod_sqrt_step(pl_t p);
		logic [18:0] tmp;
		logic [18:0] trial;
		pl_t n;
		n = p;
		tmp = {p.ls_rem, p.ls_x[31:30]};
		trial = {1'b0, p.ls_root, 2'b01};
		n.ls_x = {p.ls_x[29:0], 2'b00};
		if (tmp >= trial) begin
			n.ls_rem = 17'(tmp - trial);
			n.ls_root = {p.ls_root[14:0], 1'b1};
		end else begin
			n.ls_rem = tmp[16:0];
			n.ls_root = {p.ls_root[14:0], 1'b0};
		end
		return n;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/distance_cull_lod_select_unit.sv
// Distance cull and LOD select unit: top level, config registers and the full pipeline.
// Depends on dcl_pkg.
//
// One sphere enters per cycle while the output is not stalled; the pipeline depth is set by
// the bit-per-stage units: the 32-stage radius/d2 divider (the 25-stage distance square root
// runs beside it), then the 32-stage LOD ratio divider and the 16-stage LOD square root.
// A stalled result word holds the whole pipeline and the input in place. Config is written
// over cfg_valid/cfg_ready (always ready) and must only change while the pipeline is empty.
`default_nettype none
module distance_cull_lod_select_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic signed [23:0] center_x,
	input  wire logic signed [23:0] center_y,
	input  wire logic signed [23:0] center_z,
	input  wire logic [23:0]        radius,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    keep,
	output logic [1:0]              reject_reason,
	output logic [31:0]             ssa_value,
	output logic [16:0]             lod_factor
);

	logic signed [23:0] cam_x_q, cam_y_q, cam_z_q;
	logic [15:0]        fov_q;
	logic [31:0]        discard_q, lod_start_q, lod_end_q;

	dcl_pkg::pl_t pipe_s [1:dcl_pkg::NUM_STAGES];
	dcl_pkg::pl_t nx     [1:dcl_pkg::NUM_STAGES];
	logic [dcl_pkg::NUM_STAGES:1] vld_s;
	logic adv;

	assign cfg_ready = 1'b1;
	assign adv = !(vld_s[dcl_pkg::NUM_STAGES] && result_stall);
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			fov_q <= dcl_pkg::FOV_RESET;
			discard_q <= '0;
			lod_start_q <= '0;
			lod_end_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				dcl_pkg::CFG_CAMERA_X:  cam_x_q <= cfg_data[23:0];
				dcl_pkg::CFG_CAMERA_Y:  cam_y_q <= cfg_data[23:0];
				dcl_pkg::CFG_CAMERA_Z:  cam_z_q <= cfg_data[23:0];
				dcl_pkg::CFG_FOV:       fov_q <= cfg_data[15:0];
				dcl_pkg::CFG_DISCARD:   discard_q <= cfg_data;
				dcl_pkg::CFG_LOD_START: lod_start_q <= cfg_data;
				dcl_pkg::CFG_LOD_END:   lod_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic signed [24:0] dx, dy, dz;
		logic [32:0] rng, num;
		logic [81:0] prod;
		logic rung;
		dcl_pkg::pl_t p;

		p = pipe_s[1];
		dx = 25'(center_x) - 25'(cam_x_q);
		dy = 25'(center_y) - 25'(cam_y_q);
		dz = 25'(center_z) - 25'(cam_z_q);
		p.adx = dx[24] ? 25'(-dx) : 25'(dx);
		p.ady = dy[24] ? 25'(-dy) : 25'(dy);
		p.adz = dz[24] ? 25'(-dz) : 25'(dz);
		p.r = radius;
		nx[1] = p;
		rng = '0;
		num = '0;
		prod = '0;
		rung = 1'b0;

		for (int k = 2; k <= dcl_pkg::NUM_STAGES; k++) begin
			p = pipe_s[k-1];
			if (k == dcl_pkg::ST_SQ) begin
				p.sqx = p.adx * p.adx;
				p.sqy = p.ady * p.ady;
				p.sqz = p.adz * p.adz;
				p.rr = p.r[20:0] * p.r[20:0];
				p.rbig = |p.r[23:21];
			end
			if (k == dcl_pkg::ST_D2) begin
				p.d2 = p.sqx + p.sqy + p.sqz;
				p.plo = p.rr[20:0] * p.r[20:0];
				p.phi = p.rr[41:21] * p.r[20:0];
			end
			if (k == dcl_pkg::ST_PREP) begin
				p.dv_d = {1'b0, p.d2} + 51'd1;
				p.ssa_sat = {27'd0, p.r} >= p.dv_d;
				p.dv_rem = 51'(p.r);
				p.dv_q = '0;
				p.r3 = {21'd0, p.plo} + {p.phi[41:0], 21'd0};
				p.sq_x = p.d2;
				p.sq_rem = '0;
				p.sq_root = '0;
			end
			if (k == dcl_pkg::ST_VMUL) begin
				p.mlo = p.r3[31:0] * dcl_pkg::VOL_K;
				p.mhi = p.r3[62:32] * dcl_pkg::VOL_K;
			end
			if (k == dcl_pkg::ST_VOL) begin
				prod = {31'd0, p.mlo} + {p.mhi, 32'd0};
				p.vol = (p.rbig || (|prod[81:64])) ? '1 : prod[63:32];
			end
			if (k >= dcl_pkg::ST_DSQ0 && k <= dcl_pkg::ST_DSQN)
				p = dcl_pkg::dist_step(p);
			if (k >= dcl_pkg::ST_DIV0 && k <= dcl_pkg::ST_DIVN)
				p = dcl_pkg::ssa_div_step(p);
			if (k == dcl_pkg::ST_SCALE)
				p.scaled = p.sq_root * fov_q;
			if (k == dcl_pkg::ST_RUNG) begin
				rung = 1'b0;
				for (int i = 0; i < dcl_pkg::RUNGS; i++)
					if (p.vol < dcl_pkg::RUNG_VOL[i] && p.scaled > dcl_pkg::RUNG_DIST[i])
						rung = 1'b1;
				p.rung = rung;
			end
			if (k == dcl_pkg::ST_SSA) begin
				p.ssa = p.ssa_sat ? '1 : p.dv_q;
				if (p.rung)
					p.reason = dcl_pkg::RSN_SIZE;
				else if (p.ssa <= discard_q)
					p.reason = dcl_pkg::RSN_SSA;
				else
					p.reason = dcl_pkg::RSN_KEEP;
				rng = {1'b0, lod_start_q} - {1'b0, lod_end_q};
				num = {1'b0, p.ssa} - {1'b0, lod_end_q};
				if ($signed(rng) <= 33'sd1)
					p.mode = dcl_pkg::LM_FULL;
				else if (p.ssa <= lod_end_q)
					p.mode = dcl_pkg::LM_ZERO;
				else if (num >= rng)
					p.mode = dcl_pkg::LM_FULL;
				else
					p.mode = dcl_pkg::LM_DIV;
				p.rng = rng[31:0];
				p.ld_rem = num[31:0];
				p.ld_q = '0;
			end
			if (k >= dcl_pkg::ST_LDIV0 && k <= dcl_pkg::ST_LDIVN)
				p = dcl_pkg::lod_div_step(p);
			if (k == dcl_pkg::ST_LSQ0) begin
				p.ls_x = p.ld_q;
				p.ls_rem = '0;
				p.ls_root = '0;
			end
			if (k >= dcl_pkg::ST_LSQ0 && k <= dcl_pkg::ST_LSQN)
				p = dcl_pkg::lod_sqrt_step(p);
			if (k == dcl_pkg::ST_LOD) begin
				if (p.reason != dcl_pkg::RSN_KEEP)
					p.lod = '0;
				else begin
					case (p.mode)
						dcl_pkg::LM_FULL: p.lod = dcl_pkg::LOD_ONE;
						dcl_pkg::LM_ZERO: p.lod = '0;
						default:          p.lod = {1'b0, p.ls_root};
					endcase
				end
			end
			nx[k] = p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[dcl_pkg::NUM_STAGES-1:1], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= dcl_pkg::NUM_STAGES; k++)
				pipe_s[k] <= nx[k];
		end
	end

	assign result_valid  = vld_s[dcl_pkg::NUM_STAGES];
	assign reject_reason = pipe_s[dcl_pkg::NUM_STAGES].reason;
	assign keep          = pipe_s[dcl_pkg::NUM_STAGES].reason == dcl_pkg::RSN_KEEP;
	assign ssa_value     = pipe_s[dcl_pkg::NUM_STAGES].ssa;
	assign lod_factor    = pipe_s[dcl_pkg::NUM_STAGES].lod;

	a_reject_no_lod: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !keep |-> lod_factor == 17'd0)
		else $error("rejected word carries nonzero lod");

	a_lod_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> lod_factor <= dcl_pkg::LOD_ONE)
		else $error("lod above one");

	a_reason_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> reject_reason == dcl_pkg::RSN_KEEP ||
			reject_reason == dcl_pkg::RSN_SIZE || reject_reason == dcl_pkg::RSN_SSA)
		else $error("bad reject reason");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without output back-pressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> $stable(vld_s))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire
